// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the sampler target usage scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define STS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sts_pkg.sv =====
// Package: beat types, character constants and byte classes of the usage scanner.
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

   localparam int TARGET_COUNT = 5;
   localparam int MASK_WIDTH   = 32;

   localparam int TGT_1D   = 0;
   localparam int TGT_2D   = 1;
   localparam int TGT_3D   = 2;
   localparam int TGT_CUBE = 3;
   localparam int TGT_RECT = 4;

   localparam int MARKER_LENGTH = 8;
   localparam logic [7:0] MARKER_TEXT [MARKER_LENGTH] =
      '{"t", "e", "x", "t", "u", "r", "e", "["};

   localparam logic [7:0] CHAR_T       = "t";
   localparam logic [7:0] CHAR_E       = "e";
   localparam logic [7:0] CHAR_ZERO    = "0";
   localparam logic [7:0] CHAR_CLOSE   = "]";
   localparam logic [7:0] CHAR_COMMA   = ",";
   localparam logic [7:0] CHAR_SEMI    = ";";
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [MASK_WIDTH-1:0] mask_1d;
      logic [MASK_WIDTH-1:0] mask_2d;
      logic [MASK_WIDTH-1:0] mask_3d;
      logic [MASK_WIDTH-1:0] mask_cube;
      logic [MASK_WIDTH-1:0] mask_rect;
   } rsp_type;

   function automatic logic is_digit_byte(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_name_byte(input logic [7:0] c);
      return is_digit_byte(c) || ((c >= "A") && (c <= "Z")) ||
             ((c >= "a") && (c <= "z")) || (c == "_");
   endfunction

   function automatic logic is_space_byte(input logic [7:0] c);
      return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sampler_target_usage_scanner_unit.sv =====
// Top level of the sampler target usage scanner: beat registers, scan logic, assertions.
//
// Usage:
//   The req channel carries one source byte per beat, with end_of_text set on the
//   final byte. Each "texture[N]" ... ", TARGET" phrase marks unit N as used with
//   TARGET (1D, 2D, 3D, CUBE or RECT).
//   The rsp channel carries exactly one beat per text: the five usage masks,
//   loaded into the output register when the final byte leaves the input register.
//   Throughput is one byte per cycle while req_stall is low: a byte goes from the
//   input register through the matcher and identifier logic into the scan state.
//   The final byte of a text waits in the input register while an earlier result
//   is still stalled in the output register; any other byte proceeds regardless.
//   req_stall rises only when the input register holds such a waiting byte.
//   Reset (synchronous, active high) clears all scan state and the valid flags of
//   both registers; the block takes bytes from the first cycle after reset.
//   After the final byte all scan state clears, so the next byte starts a new text.
//   While rsp_stall is high the result beat holds unchanged.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sampler_target_usage_scanner_unit import sts_pkg::*; #(
   parameter int UNIT_SLOTS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic                  in_valid_ff, in_valid_in;
   req_type               in_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff;
   logic                  req_accept;
   logic                  proc_go;
   logic                  result_load;
   logic                  completed;
   logic [UNIT_SLOTS-1:0] unit_bits;
   rsp_type               scan_masks;

   assign proc_go     = in_valid_ff && (!in_ff.end_of_text || !rsp_valid_ff || !rsp_stall);
   assign result_load = proc_go && in_ff.end_of_text;
   assign req_stall   = in_valid_ff && !proc_go;
   assign req_accept  = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !proc_go);
   assign rsp_valid_in = result_load || (rsp_valid_ff && rsp_stall);

   sts_unit_parser #(
      .UNIT_SLOTS(UNIT_SLOTS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (proc_go),
      .last      (in_ff.end_of_text),
      .text_byte (in_ff.text_byte),
      .completed (completed),
      .unit_bits (unit_bits)
   );

   sts_group_tracker #(
      .UNIT_SLOTS(UNIT_SLOTS)
   ) u_group (
      .clock     (clock),
      .reset     (reset),
      .step      (proc_go),
      .last      (in_ff.end_of_text),
      .text_byte (in_ff.text_byte),
      .completed (completed),
      .unit_bits (unit_bits),
      .masks     (scan_masks)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= req_data;
      end
      if (result_load) begin
         rsp_ff <= scan_masks;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `STS_ASSERT_NEXT(a_final_byte_gives_beat, result_load, rsp_valid, "no result beat")
   `STS_ASSERT_NOW(a_no_overwrite, rsp_valid && rsp_stall, !result_load, "beat overwritten")
   `STS_ASSERT_NEXT(a_byte_held, req_stall, in_valid_ff && $stable(in_ff), "byte lost")
   `STS_ASSERT_NOW(a_stall_only_on_final, req_stall, in_ff.end_of_text && rsp_valid_ff, "needless stall")

endmodule

`default_nettype wire

// ===== rtl/sts_unit_parser.sv =====
// Marker matcher and unit number parser of the usage scanner.
`timescale 1ns / 1ps
`default_nettype none

module sts_unit_parser import sts_pkg::*; #(
   parameter int UNIT_SLOTS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  last,
   input  wire logic [7:0]            text_byte,
   output logic                       completed,
   output logic [UNIT_SLOTS-1:0]      unit_bits
);

   localparam int UW = (UNIT_SLOTS > 1) ? $clog2(UNIT_SLOTS) : 1;
   localparam int VW = UW + 4;

   typedef enum logic [1:0] {NUM_IDLE, NUM_FIRST, NUM_DIGITS} num_phase_type;

   num_phase_type   phase_ff, phase_in;
   logic [2:0]      progress_ff, progress_in;
   logic [UW-1:0]   unit_ff, unit_in;
   logic            oor_ff, oor_in;
   logic [7:0]      digit_diff;
   logic [VW-1:0]   base_value;
   logic [VW-1:0]   next_value;
   logic            next_oor;

   assign digit_diff = text_byte - CHAR_ZERO;
   assign base_value = (phase_ff == NUM_FIRST) ? '0 : VW'(unit_ff);
   assign next_value = VW'(base_value * VW'(4'd10)) + VW'(digit_diff[3:0]);
   assign next_oor   = ((phase_ff != NUM_FIRST) && oor_ff) ||
                       (next_value >= VW'(UNIT_SLOTS));

   assign completed = (phase_ff == NUM_DIGITS) && (text_byte == CHAR_CLOSE);
   assign unit_bits = (completed && !oor_ff) ? (UNIT_SLOTS'(1) << unit_ff) : '0;

   always_comb begin
      phase_in    = phase_ff;
      unit_in     = unit_ff;
      oor_in      = oor_ff;
      progress_in = progress_ff;

      if (phase_ff != NUM_IDLE) begin
         if (is_digit_byte(text_byte)) begin
            oor_in   = next_oor;
            unit_in  = next_oor ? '0 : next_value[UW-1:0];
            phase_in = NUM_DIGITS;
         end else begin
            phase_in = NUM_IDLE;
         end
      end

      if (text_byte == MARKER_TEXT[progress_ff]) begin
         if (progress_ff == 3'(MARKER_LENGTH - 1)) begin
            progress_in = '0;
            phase_in    = NUM_FIRST;
            unit_in     = '0;
            oor_in      = 1'b0;
         end else begin
            progress_in = progress_ff + 3'd1;
         end
      end else if ((progress_ff == 3'd4) && (text_byte == CHAR_E)) begin
         progress_in = 3'd2;
      end else if (text_byte == CHAR_T) begin
         progress_in = 3'd1;
      end else begin
         progress_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         phase_ff    <= NUM_IDLE;
         progress_ff <= '0;
         unit_ff     <= '0;
         oor_ff      <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         progress_ff <= progress_in;
         unit_ff     <= unit_in;
         oor_ff      <= oor_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sts_group_tracker.sv =====
// Comma search, identifier reader and target mask store of the usage scanner.
`timescale 1ns / 1ps
`default_nettype none

module sts_group_tracker import sts_pkg::*; #(
   parameter int UNIT_SLOTS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  last,
   input  wire logic [7:0]            text_byte,
   input  wire logic                  completed,
   input  wire logic [UNIT_SLOTS-1:0] unit_bits,
   output rsp_type                    masks
);

   localparam int CW = (UNIT_SLOTS < MASK_WIDTH) ? UNIT_SLOTS : MASK_WIDTH;

   localparam logic [31:0] NAME_1D   = 32'h0000_3144;
   localparam logic [31:0] NAME_2D   = 32'h0000_3244;
   localparam logic [31:0] NAME_3D   = 32'h0000_3344;
   localparam logic [31:0] NAME_CUBE = 32'h4355_4245;
   localparam logic [31:0] NAME_RECT = 32'h5245_4354;

   typedef enum logic [1:0] {GRP_IDLE, GRP_SEEK, GRP_SPACE, GRP_IDENT} grp_phase_type;

   grp_phase_type          phase_ff, phase_in;
   logic [UNIT_SLOTS-1:0]  pend_ff, pend_in;
   logic [31:0]            chars_ff, chars_in;
   logic [2:0]             len_ff, len_in;
   logic [UNIT_SLOTS-1:0]  use_ff [TARGET_COUNT];
   logic [UNIT_SLOTS-1:0]  use_in [TARGET_COUNT];
   logic [UNIT_SLOTS-1:0]  final_use [TARGET_COUNT];
   logic                   close_now;
   logic [TARGET_COUNT-1:0] close_hits;
   logic [TARGET_COUNT-1:0] final_hits;

   function automatic logic [TARGET_COUNT-1:0] target_hits(input logic [31:0] chars,
                                                           input logic [2:0]  len);
      logic [TARGET_COUNT-1:0] hits;
      hits           = '0;
      hits[TGT_1D]   = (len == 3'd2) && (chars == NAME_1D);
      hits[TGT_2D]   = (len == 3'd2) && (chars == NAME_2D);
      hits[TGT_3D]   = (len == 3'd2) && (chars == NAME_3D);
      hits[TGT_CUBE] = (len == 3'd4) && (chars == NAME_CUBE);
      hits[TGT_RECT] = (len == 3'd4) && (chars == NAME_RECT);
      return hits;
   endfunction

   always_comb begin
      phase_in  = phase_ff;
      pend_in   = pend_ff;
      chars_in  = chars_ff;
      len_in    = len_ff;
      use_in    = use_ff;
      close_now = 1'b0;

      unique case (phase_ff)
         GRP_SEEK: begin
            if (text_byte == CHAR_COMMA) begin
               phase_in = GRP_SPACE;
            end else if ((text_byte == CHAR_SEMI) || (text_byte == CHAR_LF) ||
                         (text_byte == CHAR_CR)) begin
               pend_in  = '0;
               phase_in = GRP_IDLE;
            end
         end
         GRP_SPACE: begin
            if (!is_space_byte(text_byte)) begin
               if (is_name_byte(text_byte)) begin
                  phase_in = GRP_IDENT;
                  chars_in = {24'h0, text_byte};
                  len_in   = 3'd1;
               end else begin
                  close_now = 1'b1;
               end
            end
         end
         GRP_IDENT: begin
            if (is_name_byte(text_byte)) begin
               if (len_ff < 3'd4) begin
                  chars_in = {chars_ff[23:0], text_byte};
                  len_in   = len_ff + 3'd1;
               end else begin
                  len_in = 3'd5;
               end
            end else begin
               close_now = 1'b1;
            end
         end
         default: begin
         end
      endcase

      close_hits = target_hits(chars_ff, len_ff);
      if (close_now) begin
         for (int t = 0; t < TARGET_COUNT; t++) begin
            if (close_hits[t]) begin
               use_in[t] = use_ff[t] | pend_ff;
            end
         end
         pend_in  = '0;
         phase_in = GRP_IDLE;
         chars_in = '0;
         len_in   = '0;
      end

      if (completed) begin
         pend_in  = pend_in | unit_bits;
         phase_in = GRP_SEEK;
      end

      final_hits = (phase_in == GRP_IDENT) ? target_hits(chars_in, len_in) : '0;
      for (int t = 0; t < TARGET_COUNT; t++) begin
         final_use[t] = use_in[t] | (final_hits[t] ? pend_in : '0);
      end
   end

   assign masks.mask_1d   = MASK_WIDTH'(final_use[TGT_1D][CW-1:0]);
   assign masks.mask_2d   = MASK_WIDTH'(final_use[TGT_2D][CW-1:0]);
   assign masks.mask_3d   = MASK_WIDTH'(final_use[TGT_3D][CW-1:0]);
   assign masks.mask_cube = MASK_WIDTH'(final_use[TGT_CUBE][CW-1:0]);
   assign masks.mask_rect = MASK_WIDTH'(final_use[TGT_RECT][CW-1:0]);

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         phase_ff <= GRP_IDLE;
         pend_ff  <= '0;
         chars_ff <= '0;
         len_ff   <= '0;
         for (int t = 0; t < TARGET_COUNT; t++) begin
            use_ff[t] <= '0;
         end
      end else if (step) begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         chars_ff <= chars_in;
         len_ff   <= len_in;
         use_ff   <= use_in;
      end
   end

endmodule

`default_nettype wire

// ===== sim/sampler_target_usage_scanner_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the sampler target usage scanner: byte streams in, usage masks checked.
module sampler_target_usage_scanner_unit_tb;
   import sts_pkg::*;

   localparam int UNIT_SLOTS   = 32;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 8;

   typedef enum logic [1:0] {DIGITS_IDLE, DIGITS_FIRST, DIGITS_MORE} digit_state_type;
   typedef enum logic [1:0] {GROUP_IDLE, GROUP_SEEK, GROUP_SPACE, GROUP_NAME} group_state_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   sampler_target_usage_scanner_unit #(.UNIT_SLOTS(UNIT_SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // scan state of the predictor
   int                  marker_pos;
   digit_state_type     digit_state;
   int                  unit_acc;
   logic                unit_big;
   logic [31:0]         units_waiting;
   group_state_type     group_state;
   logic [31:0]         name_chars;
   int                  name_len;
   logic [31:0]         used_units [TARGET_COUNT];

   rsp_type             expected_masks [$];
   logic [7:0]          text_bytes [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int bytes_sent     = 0;
   int texts_done     = 0;
   int masks_checked  = 0;
   int idle_cycles    = 0;

   function automatic logic digit_char(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic word_char(input logic [7:0] c);
      return digit_char(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   endfunction

   function automatic logic blank_char(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic void clear_scan();
      marker_pos    = 0;
      digit_state   = DIGITS_IDLE;
      unit_acc      = 0;
      unit_big      = 1'b0;
      units_waiting = '0;
      group_state   = GROUP_IDLE;
      name_chars    = '0;
      name_len      = 0;
      for (int i = 0; i < TARGET_COUNT; i++) used_units[i] = '0;
   endfunction

   function automatic void close_name();
      int slot;
      slot = -1;
      if (name_len == 2) begin
         if (name_chars == "1D") slot = TGT_1D;
         else if (name_chars == "2D") slot = TGT_2D;
         else if (name_chars == "3D") slot = TGT_3D;
      end else if (name_len == 4) begin
         if (name_chars == "CUBE") slot = TGT_CUBE;
         else if (name_chars == "RECT") slot = TGT_RECT;
      end
      if (slot >= 0) used_units[slot] |= units_waiting;
      units_waiting = '0;
      group_state   = GROUP_IDLE;
      name_chars    = '0;
      name_len      = 0;
   endfunction

   function automatic void scan_byte(input logic [7:0] c, input logic is_final);
      int      v;
      logic    completed;
      rsp_type masks;
      completed = 1'b0;
      case (group_state)
         GROUP_SEEK: begin
            if (c == CHAR_COMMA) group_state = GROUP_SPACE;
            else if (c == CHAR_SEMI || c == CHAR_LF || c == CHAR_CR) begin
               units_waiting = '0;
               group_state   = GROUP_IDLE;
            end
         end
         GROUP_SPACE: begin
            if (!blank_char(c)) begin
               if (word_char(c)) begin
                  group_state = GROUP_NAME;
                  name_chars  = {24'd0, c};
                  name_len    = 1;
               end else close_name();
            end
         end
         GROUP_NAME: begin
            if (word_char(c)) begin
               if (name_len < 4) begin
                  name_chars = {name_chars[23:0], c};
                  name_len++;
               end else name_len = 5;
            end else close_name();
         end
         default: ;
      endcase

      if (digit_state != DIGITS_IDLE) begin
         if (digit_char(c)) begin
            v = (digit_state == DIGITS_FIRST ? 0 : unit_acc) * 10 + int'(c - CHAR_ZERO);
            if (digit_state == DIGITS_FIRST) unit_big = 1'b0;
            if (unit_big || v >= UNIT_SLOTS) begin
               unit_big = 1'b1;
               unit_acc = 0;
            end else unit_acc = v;
            digit_state = DIGITS_MORE;
         end else begin
            if (digit_state == DIGITS_MORE && c == CHAR_CLOSE) completed = 1'b1;
            digit_state = DIGITS_IDLE;
         end
      end
      if (completed) begin
         if (!unit_big) units_waiting[unit_acc] = 1'b1;
         group_state = GROUP_SEEK;
      end

      if (c == MARKER_TEXT[marker_pos]) begin
         marker_pos++;
         if (marker_pos == MARKER_LENGTH) begin
            marker_pos  = 0;
            digit_state = DIGITS_FIRST;
            unit_acc    = 0;
            unit_big    = 1'b0;
         end
      end else if (marker_pos == 4 && c == CHAR_E) marker_pos = 2;
      else if (c == CHAR_T) marker_pos = 1;
      else marker_pos = 0;

      if (is_final) begin
         if (group_state == GROUP_NAME) close_name();
         masks.mask_1d   = used_units[TGT_1D];
         masks.mask_2d   = used_units[TGT_2D];
         masks.mask_3d   = used_units[TGT_3D];
         masks.mask_cube = used_units[TGT_CUBE];
         masks.mask_rect = used_units[TGT_RECT];
         expected_masks.push_back(masks);
         clear_scan();
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic send_byte(input logic [7:0] c, input logic is_final);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {c, is_final};
      do @(posedge clock); while (req_stall);
      scan_byte(c, is_final);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_queued_text();
      int n;
      n = text_bytes.size();
      for (int i = 0; i < n; i++) send_byte(text_bytes[i], i == n - 1);
      if (n > 0) texts_done++;
      text_bytes.delete();
   endtask

   function automatic void add_string(input string s);
      for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
   endfunction

   task automatic send_text(input string s);
      add_string(s);
      send_queued_text();
   endtask

   function automatic logic [7:0] pick_blank();
      return ($urandom_range(0, 2) == 0) ? 8'h20 : 8'($urandom_range(9, 13));
   endfunction

   function automatic void add_phrase();
      string names [5]     = '{"1D", "2D", "3D", "CUBE", "RECT"};
      string odd_names [5] = '{"CUBEMAP", "2DARRAY", "1d", "RECTANGLE", "Cube"};
      string word_pool     = "abcXYZ_019DCUBERT";
      string filler_pool   = " (xy.+*)tex]";
      string end_pool      = ");, \n";
      int pick;
      add_string("texture[");
      pick = $urandom_range(0, 9);
      if (pick < 6) add_string($sformatf("%0d", $urandom_range(0, 31)));
      else if (pick < 7) add_string($sformatf("00%0d", $urandom_range(0, 40)));
      else if (pick < 9) add_string($sformatf("%0d", $urandom_range(32, 1200)));
      if ($urandom_range(0, 9) != 0) text_bytes.push_back(CHAR_CLOSE);
      else text_bytes.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 4))
         text_bytes.push_back(filler_pool[$urandom_range(0, filler_pool.len() - 1)]);
      if ($urandom_range(0, 4) == 0) add_string($sformatf("texture[%0d]", $urandom_range(0, 35)));
      if ($urandom_range(0, 7) == 0) begin
         pick = $urandom_range(0, 2);
         text_bytes.push_back(pick == 0 ? CHAR_SEMI : pick == 1 ? CHAR_LF : CHAR_CR);
      end
      text_bytes.push_back(CHAR_COMMA);
      repeat ($urandom_range(0, 3)) text_bytes.push_back(pick_blank());
      pick = $urandom_range(0, 9);
      if (pick < 7) add_string(names[$urandom_range(0, 4)]);
      else if (pick < 8) add_string(odd_names[$urandom_range(0, 4)]);
      else if (pick < 9)
         repeat ($urandom_range(1, 6))
            text_bytes.push_back(word_pool[$urandom_range(0, word_pool.len() - 1)]);
      text_bytes.push_back(end_pool[$urandom_range(0, end_pool.len() - 1)]);
   endfunction

   function automatic void add_noise();
      string partials [6] = '{"tex", "textexture[", "texttexture[", "texture",
                              "TEXTURE[1],2D", "texture[ 3],2D"};
      if ($urandom_range(0, 1) == 0)
         repeat ($urandom_range(1, 8)) text_bytes.push_back(8'($urandom_range(0, 255)));
      else add_string(partials[$urandom_range(0, 5)]);
   endfunction

   task automatic test_target_names();
      send_text("texture[0],1D;texture[31], 2D\ntexture[7],\t3D");
      send_text("texture[12],CUBE x texture[5] ,RECT");
   endtask

   task automatic test_special_cases();
      send_text("texture[32],1D texture[999],2D texture[031],3D");
      send_text("texture[3],CUBEMAP texture[4], ;texture[1];,1D texture[],2D");
      send_text("texture[2]texture[9],RECT textexture[1],3D texture[6]");
      send_text("texture[1");
      text_bytes.push_back(8'h00);
      text_bytes.push_back(8'hFF);
      send_queued_text();
   endtask

   task automatic test_random_texts(input int budget);
      int first;
      int keep;
      first = bytes_sent;
      while (bytes_sent - first < budget) begin
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 4) != 0) add_phrase();
            else add_noise();
         end
         if ($urandom_range(0, 6) == 0) begin
            keep = $urandom_range(1, text_bytes.size());
            while (text_bytes.size() > keep) void'(text_bytes.pop_back());
         end
         send_queued_text();
      end
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);

   always @(posedge clock) begin : check_beat
      string   field_names [TARGET_COUNT] = '{"mask_1d", "mask_2d", "mask_3d",
                                              "mask_cube", "mask_rect"};
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_masks.size() == 0) report_mismatch("result beat with no text pending");
         else begin
            want = expected_masks.pop_front();
            masks_checked++;
            for (int i = 0; i < TARGET_COUNT; i++)
               if (rsp_data[(TARGET_COUNT - 1 - i) * MASK_WIDTH +: MASK_WIDTH] !==
                   want[(TARGET_COUNT - 1 - i) * MASK_WIDTH +: MASK_WIDTH])
                  report_mismatch($sformatf("%s got %h expected %h", field_names[i],
                     rsp_data[(TARGET_COUNT - 1 - i) * MASK_WIDTH +: MASK_WIDTH],
                     want[(TARGET_COUNT - 1 - i) * MASK_WIDTH +: MASK_WIDTH]));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_masks.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      clear_scan();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_target_names();
      test_special_cases();
      send_idle_pct  = 36;
      recv_stall_pct = 51;
      test_random_texts(500);
      send_idle_pct  = 51;
      recv_stall_pct = 36;
      test_random_texts(500);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_texts(450);
      req_valid <= 1'b0;
      while (expected_masks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("scanned %0d bytes in %0d texts under three idle/stall mixes", bytes_sent,
               texts_done);
      $display("checked %0d mask results, %0d mismatches", masks_checked, error_count);
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
